FILE: hw/rtl/msr_pkg.sv
// masked running statistics: shared types, constants and helper functions
// no dependencies
`timescale 1ns / 1ps
package msr_pkg;
    localparam int MaxDims    = 16;
    localparam int MaxSamples = 65536;
    localparam int QueueDepth = 4;

    localparam logic REQ_ACCUM  = 1'b0;
    localparam logic REQ_FINISH = 1'b1;

    typedef struct packed {
        logic              req_type;
        logic [3:0]        element_index;
        logic signed [15:0] value;
        logic              included;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_qout;

    // dims_in_use 0 acts as 1, anything above the table depth as the depth
    function automatic logic [4:0] eff_dims(input logic [4:0] cfg);
        logic [4:0] d;
        d = cfg;
        if (d == 5'd0) d = 5'd1;
        if (d > 5'(MaxDims)) d = 5'(MaxDims);
        return d;
    endfunction
endpackage

FILE: hw/rtl/msr_front.sv
// masked running statistics: front end with config register, item filter and queue
// depends on msr_pkg
`timescale 1ns / 1ps
module msr_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    output logic                 o_full,
    input  logic                 i_req_type,
    input  logic [3:0]           i_element_index,
    input  logic signed [15:0]   i_value,
    input  logic                 i_included,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [4:0]           i_cfg_data,
    output msr_pkg::t_qout       o_q,
    input  logic                 i_q_pop,
    output logic [4:0]           o_dims
);
    import msr_pkg::*;

    t_item      r_mem [QueueDepth];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_fill;
    logic [4:0] r_cfg;
    logic       accept, keep, wr, rd;
    t_item      in_item;

    assign o_cfg_ready = 1'b1;
    assign o_dims      = eff_dims(r_cfg);
    assign o_full      = (r_fill == 3'(QueueDepth));
    assign accept      = i_push && !o_full;
    assign in_item     = '{i_req_type, i_element_index, i_value, i_included};
    // masked or untracked elements never reach the back end
    assign keep        = (i_req_type == REQ_FINISH) ||
                         (i_included && ({1'b0, i_element_index} < o_dims));
    assign wr          = accept && keep;
    assign rd          = i_q_pop && (r_fill != 3'd0);
    assign o_q.valid   = (r_fill != 3'd0);
    assign o_q.item    = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= 5'd1;
        end else if (i_cfg_valid) begin
            r_cfg <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_fill <= '0;
        end else begin
            if (wr) r_wp <= r_wp + 2'd1;
            if (rd) r_rp <= r_rp + 2'd1;
            r_fill <= r_fill + 3'(wr) - 3'(rd);
        end
    end
endmodule

FILE: hw/rtl/msr_back.sv
// masked running statistics: accumulator table, finish sequencer with shared
// shift-add multiplier, restoring divider, digit square root and output register
// depends on msr_pkg
`timescale 1ns / 1ps
module msr_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  msr_pkg::t_qout       i_q,
    output logic                 o_q_pop,
    input  logic [4:0]           i_dims,
    output logic                 o_empty,
    input  logic                 i_pop,
    output logic [3:0]           o_out_index,
    output logic [16:0]          o_sample_count,
    output logic signed [15:0]   o_min_value,
    output logic signed [15:0]   o_max_value,
    output logic signed [23:0]   o_mean_value,
    output logic [23:0]          o_std_dev,
    output logic                 o_overflowed,
    output logic                 o_last_result
);
    import msr_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_LOAD  = 4'd1;
    localparam logic [3:0] S_MDIV  = 4'd2;
    localparam logic [3:0] S_MUL1  = 4'd3;
    localparam logic [3:0] S_MUL2  = 4'd4;
    localparam logic [3:0] S_DIFF  = 4'd5;
    localparam logic [3:0] S_SDIV  = 4'd6;
    localparam logic [3:0] S_SQRT  = 4'd7;
    localparam logic [3:0] S_EMIT  = 4'd8;
    localparam logic [3:0] S_CLEAR = 4'd9;

    // accumulator table
    logic [16:0]        r_cnt [MaxDims];
    logic signed [15:0] r_min [MaxDims];
    logic signed [15:0] r_max [MaxDims];
    logic signed [32:0] r_sum [MaxDims];
    logic [46:0]        r_sq  [MaxDims];
    logic               r_ovf [MaxDims];

    logic [3:0]         r_state, n_state;
    logic [3:0]         r_k;
    logic [6:0]         r_step;
    logic [16:0]        r_n;
    logic               r_neg;
    logic [31:0]        r_mag;
    logic [46:0]        r_sqs;
    logic signed [15:0] r_mn, r_mx;
    logic               r_ov;
    logic [31:0]        r_den_sd;
    logic signed [23:0] r_mean;
    logic [23:0]        r_sd;
    // shared multiplier
    logic [63:0]        r_ma, r_acc, r_a;
    logic [31:0]        r_mb;
    // shared divider
    logic [79:0]        r_dvd;
    logic [31:0]        r_den, r_rem;
    logic [63:0]        r_quo;
    // square root
    logic [63:0]        r_x, r_res, r_bit;
    // output register
    logic               r_out_valid;

    t_item              it;
    logic [3:0]         ai;
    logic signed [15:0] v;
    logic [31:0]        vsq;
    logic               acc_go, fin_go, emit_ok, last_k;
    logic [32:0]        rem2;
    logic               dsub;
    logic [31:0]        n_rem;
    logic [63:0]        n_quo;
    logic [63:0]        n_acc;
    logic [63:0]        rb;
    logic               sq_take;
    logic [16:0]        ld_n;
    logic signed [32:0] ld_s;
    logic [32:0]        ld_negs;

    assign it      = i_q.item;
    assign ai      = it.element_index;
    assign v       = it.value;
    assign vsq     = 32'(v * v);
    assign acc_go  = (r_state == S_IDLE) && i_q.valid && (it.req_type == REQ_ACCUM);
    assign fin_go  = (r_state == S_IDLE) && i_q.valid && (it.req_type == REQ_FINISH);
    assign o_q_pop = acc_go || fin_go;
    assign emit_ok = !r_out_valid || i_pop;
    assign last_k  = (5'(r_k) + 5'd1 == i_dims);

    // divider step
    assign rem2  = {r_rem, r_dvd[79]};
    assign dsub  = (rem2 >= {1'b0, r_den});
    assign n_rem = dsub ? 32'(rem2 - {1'b0, r_den}) : rem2[31:0];
    assign n_quo = {r_quo[62:0], dsub};
    // multiplier step
    assign n_acc = r_mb[0] ? r_acc + r_ma : r_acc;
    // square root step
    assign rb      = r_res + r_bit;
    assign sq_take = (r_x >= rb);

    assign ld_n    = r_cnt[r_k];
    assign ld_s    = r_sum[r_k];
    assign ld_negs = 33'(-ld_s);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (fin_go) n_state = S_LOAD;
            S_LOAD:  n_state = (ld_n <= 17'd1) ? S_EMIT : S_MDIV;
            S_MDIV:  if (r_step == 7'd79) n_state = S_MUL1;
            S_MUL1:  if (r_step == 7'd31) n_state = S_MUL2;
            S_MUL2:  if (r_step == 7'd31) n_state = S_DIFF;
            S_DIFF:  n_state = (r_a < r_acc) ? S_EMIT : S_SDIV;
            S_SDIV:  if (r_step == 7'd79) n_state = S_SQRT;
            S_SQRT:  if (r_step == 7'd31) n_state = S_EMIT;
            S_EMIT:  if (emit_ok) n_state = last_k ? S_CLEAR : S_LOAD;
            S_CLEAR: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // accumulator table: one read-modify-write per element, cleared after a finish
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || r_state == S_CLEAR) begin
            for (int i = 0; i < MaxDims; i++) begin
                r_cnt[i] <= '0;
                r_min[i] <= 16'sh7fff;
                r_max[i] <= -16'sh8000;
                r_sum[i] <= '0;
                r_sq[i]  <= '0;
                r_ovf[i] <= 1'b0;
            end
        end else if (acc_go) begin
            if (r_cnt[ai] == 17'(MaxSamples)) begin
                r_ovf[ai] <= 1'b1;
            end else begin
                r_cnt[ai] <= r_cnt[ai] + 17'd1;
                r_sum[ai] <= r_sum[ai] + 33'(v);
                r_sq[ai]  <= r_sq[ai] + 47'(vsq);
                if (v < r_min[ai]) r_min[ai] <= v;
                if (v > r_max[ai]) r_max[ai] <= v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= '0;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            if (n_state != r_state) r_step <= '0;
            else r_step <= r_step + 7'd1;
            if (fin_go) r_k <= '0;
            else if (r_state == S_EMIT && emit_ok && !last_k) r_k <= r_k + 4'd1;
        end
    end

    // finish datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_LOAD: begin
                r_n      <= ld_n;
                r_neg    <= ld_s[32];
                r_mag    <= ld_s[32] ? ld_negs[31:0] : ld_s[31:0];
                r_sqs    <= r_sq[r_k];
                r_mn     <= r_min[r_k];
                r_mx     <= r_max[r_k];
                r_ov     <= r_ovf[r_k];
                r_den_sd <= 32'(ld_n * (ld_n - 17'd1));
                r_sd     <= '0;
                r_mean   <= 24'(ld_s <<< 8);
                r_dvd    <= 80'({ld_s[32] ? ld_negs[31:0] : ld_s[31:0], 8'd0});
                r_den    <= 32'(ld_n);
                r_rem    <= '0;
                r_quo    <= '0;
            end
            S_MDIV: begin
                r_rem <= n_rem;
                r_quo <= n_quo;
                r_dvd <= {r_dvd[78:0], 1'b0};
                if (r_step == 7'd79) begin
                    // quotient magnitude never exceeds 2^23
                    r_mean <= r_neg ? 24'(-{n_quo[23:0]}) : n_quo[23:0];
                    r_acc  <= '0;
                    r_ma   <= 64'(r_sqs);
                    r_mb   <= 32'(r_n);
                end
            end
            S_MUL1, S_MUL2: begin
                r_acc <= n_acc;
                r_ma  <= {r_ma[62:0], 1'b0};
                r_mb  <= {1'b0, r_mb[31:1]};
                if (r_state == S_MUL1 && r_step == 7'd31) begin
                    r_a   <= n_acc;
                    r_acc <= '0;
                    r_ma  <= 64'(r_mag);
                    r_mb  <= r_mag;
                end
            end
            S_DIFF: begin
                r_dvd <= {r_a - r_acc, 16'd0};
                r_den <= r_den_sd;
                r_rem <= '0;
                r_quo <= '0;
            end
            S_SDIV: begin
                r_rem <= n_rem;
                r_quo <= n_quo;
                r_dvd <= {r_dvd[78:0], 1'b0};
                if (r_step == 7'd79) begin
                    r_x   <= n_quo;
                    r_res <= '0;
                    r_bit <= 64'd1 << 62;
                end
            end
            S_SQRT: begin
                if (sq_take) begin
                    r_x   <= r_x - rb;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
                if (r_step == 7'd31) begin
                    r_sd <= sq_take ? (((r_res >> 1) + r_bit > 64'hffffff) ? 24'hffffff
                                       : 24'((r_res >> 1) + r_bit))
                                    : (((r_res >> 1) > 64'hffffff) ? 24'hffffff
                                       : 24'(r_res >> 1));
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_EMIT && emit_ok) begin
            r_out_valid <= 1'b1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_EMIT && emit_ok) begin
            o_out_index    <= r_k;
            o_sample_count <= r_n;
            o_min_value    <= r_mn;
            o_max_value    <= r_mx;
            o_mean_value   <= r_mean;
            o_std_dev      <= r_sd;
            o_overflowed   <= r_ov;
            o_last_result  <= last_k;
        end
    end

    assign o_empty = !r_out_valid;

    a_fin_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fin_go |=> (r_state == S_LOAD) && (r_k == 4'd0))
        else $error("finish did not start at position zero");
    a_few_sd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) && (r_n <= 17'd1) |-> (r_sd == 24'd0))
        else $error("std dev nonzero with fewer than two samples");
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |=> (r_cnt[0] == 17'd0) && !r_ovf[0])
        else $error("accumulators not cleared after finish");
    a_no_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_q_pop)
        else $error("queue popped during finish pass");
endmodule

FILE: hw/rtl/masked_running_statistics.sv
// masked running statistics: top level joining front end and back end
// depends on msr_pkg, msr_front, msr_back
//
// usage: items enter through a queue-style port (i_push / o_full); an item is
// taken on a clock edge with i_push high and o_full low. an accumulate request
// updates count, min, max, sum and sum of squares of its element position, or
// only its overflow flag once the count is 65536, as it leaves the four-entry
// queue; masked or untracked elements are dropped at the front. a finish
// request walks every tracked position and emits one result each (o_empty /
// i_pop), then clears the table. throughput: one accumulate request per cycle
// except behind a finish, where they queue. per position a finish runs the
// restoring divider, the bit-serial multiplier twice, the divider and the
// square root, all skipped with at most one sample. the user must write
// dims_in_use through i_cfg_valid / o_cfg_ready / i_cfg_data only while the
// block is idle; the block does not enforce it. reset (synchronous, active
// low) sets dims_in_use to 1 and clears all accumulators. while the receiver
// holds off i_pop the result stays on the ports and the queue fills to o_full.
`timescale 1ns / 1ps
module masked_running_statistics (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    output logic                 o_full,
    input  logic                 i_req_type,
    input  logic [3:0]           i_element_index,
    input  logic signed [15:0]   i_value,
    input  logic                 i_included,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [4:0]           i_cfg_data,
    output logic                 o_empty,
    input  logic                 i_pop,
    output logic [3:0]           o_out_index,
    output logic [16:0]          o_sample_count,
    output logic signed [15:0]   o_min_value,
    output logic signed [15:0]   o_max_value,
    output logic signed [23:0]   o_mean_value,
    output logic [23:0]          o_std_dev,
    output logic                 o_overflowed,
    output logic                 o_last_result
);
    import msr_pkg::*;

    t_qout      q;
    logic       q_pop;
    logic [4:0] dims;

    msr_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (i_push),
        .o_full          (o_full),
        .i_req_type      (i_req_type),
        .i_element_index (i_element_index),
        .i_value         (i_value),
        .i_included      (i_included),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .o_q             (q),
        .i_q_pop         (q_pop),
        .o_dims          (dims)
    );

    msr_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q            (q),
        .o_q_pop        (q_pop),
        .i_dims         (dims),
        .o_empty        (o_empty),
        .i_pop          (i_pop),
        .o_out_index    (o_out_index),
        .o_sample_count (o_sample_count),
        .o_min_value    (o_min_value),
        .o_max_value    (o_max_value),
        .o_mean_value   (o_mean_value),
        .o_std_dev      (o_std_dev),
        .o_overflowed   (o_overflowed),
        .o_last_result  (o_last_result)
    );
endmodule
